FILE: rtl/core/owo_pkg.sv
// Shared constants, types and the arctangent table of the omni wheel odometry block.
package owo_pkg;

	// Widths of the item fields.
	localparam int COUNT_W   = 16;
	localparam int HEAD_W    = 16;
	localparam int GAIN_W    = 17;
	localparam int SCALE_W   = 24;
	localparam int VEL_W     = 32;
	localparam int POS_W     = 48;
	localparam int SPEED_W   = COUNT_W + SCALE_W;
	localparam int TRIG_W    = 16;
	localparam int LANES     = 4;
	localparam int IN_DATA_W = 80;
	localparam int OUT_DATA_W = 160;
	localparam int CFG_W     = 24;

	// Default heading resolution in bits of a full turn.
	localparam int ANGLE_BITS_DEF = 16;

	// Configuration register indexes.
	localparam logic [0:0] REG_FILTER_GAIN = 1'd0;
	localparam logic [0:0] REG_SPEED_SCALE = 1'd1;

	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 17'd6554;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
	localparam logic [GAIN_W-1:0]  GAIN_ONE    = 17'd65536;

	// Rotation CORDIC: iteration count and pre-scaled start value in Q2.30.
	localparam int CORDIC_STEPS = 20;
	localparam int CORDIC_W     = 33;
	localparam logic signed [CORDIC_W-1:0] CORDIC_START = 33'sd652032874;

	typedef logic signed [SPEED_W-1:0] speed_t;
	typedef logic signed [TRIG_W-1:0]  trig_t;

	// Step enables handed from the sequencer to the merging stage.
	typedef struct packed {
		logic mul_en;
		logic sum_en;
		logic load;
	} merge_ctrl_t;

	// atan(2^-i) in units of 2^-32 turn, truncated.
	function automatic logic [29:0] cordic_atan(input logic [4:0] idx);
		logic [29:0] a;
		unique case (idx)
			5'd0:  a = 30'h20000000;
			5'd1:  a = 30'h12E4051D;
			5'd2:  a = 30'h09FB385B;
			5'd3:  a = 30'h051111D4;
			5'd4:  a = 30'h028B0D43;
			5'd5:  a = 30'h0145D7E1;
			5'd6:  a = 30'h00A2F61E;
			5'd7:  a = 30'h00517C55;
			5'd8:  a = 30'h0028BE53;
			5'd9:  a = 30'h00145F2E;
			5'd10: a = 30'h000A2F98;
			5'd11: a = 30'h000517CC;
			5'd12: a = 30'h00028BE6;
			5'd13: a = 30'h000145F3;
			5'd14: a = 30'h0000A2F9;
			5'd15: a = 30'h0000517C;
			5'd16: a = 30'h000028BE;
			5'd17: a = 30'h0000145F;
			5'd18: a = 30'h00000A2F;
			5'd19: a = 30'h00000517;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

FILE: rtl/core/owo_lane.sv
// One wheel lane: low-pass filter of the encoder count and scaling to wheel speed.
module owo_lane (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  logic [owo_pkg::GAIN_W-1:0]      gain,
	input  logic [owo_pkg::SCALE_W-1:0]     scale,
	input  logic signed [owo_pkg::COUNT_W-1:0] raw,
	output owo_pkg::speed_t                 speed
);
	import owo_pkg::*;

	logic [GAIN_W-1:0]         g;
	logic [GAIN_W-1:0]         w;
	logic signed [33:0]        keep_p;
	logic signed [33:0]        new_p;
	logic signed [34:0]        sum;
	logic signed [18:0]        quo;
	logic signed [COUNT_W-1:0] next_f;
	logic signed [COUNT_W-1:0] filt_q;
	speed_t                    speed_q;

	always_comb begin
		g      = (gain > GAIN_ONE) ? GAIN_ONE : gain;
		w      = GAIN_ONE - g;
		keep_p = $signed({1'b0, w}) * filt_q;
		new_p  = $signed({1'b0, g}) * raw;
		sum    = 35'(keep_p) + 35'(new_p);
		// Division by 2^16 truncating toward zero.
		if (sum[34]) begin
			quo = 19'((sum + 35'sd65535) >>> 16);
		end else begin
			quo = 19'(sum >>> 16);
		end
		// Magnitudes of one or less are treated as standstill.
		if (quo >= -19'sd1 && quo <= 19'sd1) begin
			next_f = '0;
		end else begin
			next_f = quo[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
		end else if (load) begin
			filt_q <= next_f;
		end
	end

	always_ff @(posedge clk) begin
		speed_q <= filt_q * $signed({1'b0, scale});
	end

	assign speed = speed_q;

endmodule

FILE: rtl/core/owo_cordic.sv
// Iterative rotation CORDIC giving cosine and sine of the heading in Q1.15.
module owo_cordic #(
	parameter int ANGLE_BITS = owo_pkg::ANGLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [owo_pkg::HEAD_W-1:0]    heading,
	output logic                          done,
	output owo_pkg::trig_t                cos_v,
	output owo_pkg::trig_t                sin_v
);
	import owo_pkg::*;

	localparam logic [31:0] KEEP = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
	localparam logic [4:0]  LAST_STEP = 5'(CORDIC_STEPS - 1);

	function automatic trig_t to_q15(input logic signed [CORDIC_W-1:0] v);
		logic signed [17:0] r;
		trig_t q;
		r = 18'((v + 33'sd16384) >>> 15);
		if (r > 18'sd32767) begin
			q = 16'sd32767;
		end else if (r < -18'sd32767) begin
			q = -16'sd32767;
		end else begin
			q = r[TRIG_W-1:0];
		end
		return q;
	endfunction

	logic [31:0]                 phase;
	logic signed [CORDIC_W-1:0]  x_q, y_q, z_q;
	logic signed [CORDIC_W-1:0]  xs, ys, atan_s;
	logic [1:0]                  quad_q;
	logic [4:0]                  step_q;
	logic                        run_q, fin_q, done_q;
	trig_t                       cr, sr;
	trig_t                       cos_q, sin_q;

	assign phase  = {heading, 16'b0} & KEEP;
	assign xs     = x_q >>> step_q;
	assign ys     = y_q >>> step_q;
	assign atan_s = $signed({3'b000, cordic_atan(step_q)});
	assign cr     = to_q15(x_q);
	assign sr     = to_q15(y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			fin_q  <= run_q && (step_q == LAST_STEP);
			done_q <= fin_q;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				if (step_q == LAST_STEP) begin
					run_q <= 1'b0;
				end
				step_q <= step_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_START;
			y_q    <= '0;
			z_q    <= $signed({3'b000, phase[29:0]});
			quad_q <= phase[31:30];
		end else if (run_q) begin
			if (!z_q[CORDIC_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_s;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_s;
			end
		end
		// Fold the first-quadrant result into the true quadrant.
		if (fin_q) begin
			unique case (quad_q)
				2'd1: begin
					cos_q <= -sr;
					sin_q <= cr;
				end
				2'd2: begin
					cos_q <= -cr;
					sin_q <= -sr;
				end
				2'd3: begin
					cos_q <= sr;
					sin_q <= -cr;
				end
				default: begin
					cos_q <= cr;
					sin_q <= sr;
				end
			endcase
		end
	end

	assign done  = done_q;
	assign cos_v = cos_q;
	assign sin_v = sin_q;

endmodule

FILE: rtl/core/owo_merge.sv
// Merging stage: rotation of the wheel speeds, rounding, position sums and output register.
module owo_merge (
	input  logic                               clk,
	input  logic                               arst_n,
	input  owo_pkg::merge_ctrl_t               ctrl,
	input  owo_pkg::speed_t                    speed [owo_pkg::LANES],
	input  owo_pkg::trig_t                     cos_v,
	input  owo_pkg::trig_t                     sin_v,
	output logic                               out_free,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [owo_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import owo_pkg::*;

	function automatic logic signed [VEL_W-1:0] vel_round(input logic signed [57:0] v);
		logic signed [41:0] r;
		logic signed [VEL_W-1:0] q;
		r = 42'((v + 58'sd32768) >>> 16);
		if (r > 42'sd2147483647) begin
			q = 32'sh7FFFFFFF;
		end else if (r < -42'sd2147483648) begin
			q = 32'sh80000000;
		end else begin
			q = r[VEL_W-1:0];
		end
		return q;
	endfunction

	logic signed [SPEED_W:0]  da, db;
	logic signed [56:0]       pdc_s1, pds_s1, pac_s1, pas_s1;
	logic signed [VEL_W-1:0]  vx_s2, vy_s2;
	logic [POS_W-1:0]         acc_x_q, acc_y_q, nx, ny;
	logic [OUT_DATA_W-1:0]    data_q;
	logic                     valid_q;

	assign da = (SPEED_W+1)'(speed[2]) - (SPEED_W+1)'(speed[0]);
	assign db = (SPEED_W+1)'(speed[1]) - (SPEED_W+1)'(speed[3]);
	assign nx = acc_x_q + POS_W'(vx_s2);
	assign ny = acc_y_q + POS_W'(vy_s2);

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			pdc_s1 <= da * cos_v;
			pds_s1 <= db * sin_v;
			pac_s1 <= da * sin_v;
			pas_s1 <= db * cos_v;
		end
		if (ctrl.sum_en) begin
			vx_s2 <= vel_round(58'(pdc_s1) + 58'(pds_s1));
			vy_s2 <= vel_round(58'(pac_s1) - 58'(pas_s1));
		end
		if (ctrl.load) begin
			data_q <= {ny, nx, vy_s2, vx_s2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (ctrl.load) begin
				acc_x_q <= nx;
				acc_y_q <= ny;
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_free = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule

FILE: rtl/core/omni_wheel_odometry.sv
// Top level of the four-wheel omni odometry block: sequencer, wheel lanes, CORDIC and merge.
//
// Each input transaction carries one frame of four signed encoder counts and the heading;
// each produces exactly one output transaction with the field-frame velocity (Q16.16,
// saturated) and the wrapping X/Y position sums (Q32.16). Four lanes filter and scale the
// wheel counts side by side while a single iterative CORDIC unit works out cosine and sine
// of the heading, one micro-rotation per clock; the merging stage then rotates the wheel
// speed differences, rounds, and updates the position accumulators. From acceptance, an
// item passes the CORDIC iterations, the quadrant fold, the products and the rounded sums
// before its result enters the output register; a new item is taken in the cycle after
// that, so items do not overlap: none is taken before the last has reached that register.
// The output register lets the next item be accepted while a result still waits
// to be taken; if it is still occupied at the end of the next item, that item waits in
// the merge stage. Configuration writes belong in idle periods between items.
module omni_wheel_odometry #(
	parameter int ANGLE_BITS = owo_pkg::ANGLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// s_tdata, lowest bit first: wheel_a_count, wheel_b_count, wheel_c_count,
	// wheel_d_count, heading
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [owo_pkg::IN_DATA_W-1:0]     s_tdata,
	// m_tdata, lowest bit first: vel_x, vel_y, pos_x, pos_y
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [owo_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                              cfg_we,
	input  logic [0:0]                        cfg_index,
	input  logic [owo_pkg::CFG_W-1:0]         cfg_data
);
	import owo_pkg::*;

	// Sequencer states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_SUM  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]         state_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [SCALE_W-1:0] scale_q;
	logic               accept;
	logic               cdone;
	logic               out_free;
	trig_t              cos_v, sin_v;
	speed_t             speed [LANES];
	merge_ctrl_t        ctrl;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Configuration registers; the write port has no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RESET;
			scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FILTER_GAIN: gain_q  <= cfg_data[GAIN_W-1:0];
				REG_SPEED_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// The lanes update their filter state on the accepting edge itself, so the scaled
	// speeds are settled long before the CORDIC finishes.
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		owo_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (accept),
			.gain   (gain_q),
			.scale  (scale_q),
			.raw    ($signed(s_tdata[COUNT_W*i +: COUNT_W])),
			.speed  (speed[i])
		);
	end

	owo_cordic #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.heading (s_tdata[COUNT_W*LANES +: HEAD_W]),
		.done    (cdone),
		.cos_v   (cos_v),
		.sin_v   (sin_v)
	);

	// The merge runs its products the cycle the CORDIC reports done, the rounded sums in the
	// cycle after, and loads the output register once that register is free.
	always_comb begin
		ctrl.mul_en = (state_q == ST_RUN) && cdone;
		ctrl.sum_en = (state_q == ST_SUM);
		ctrl.load   = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) begin
					state_q <= ST_RUN;
				end
				ST_RUN: if (cdone) begin
					state_q <= ST_SUM;
				end
				ST_SUM: state_q <= ST_OUT;
				ST_OUT: if (out_free) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	owo_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.speed    (speed),
		.cos_v    (cos_v),
		.sin_v    (sin_v),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// An accepted item always starts the CORDIC run.
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_RUN)
		else $error("accepted item did not start a run");

	// The CORDIC only finishes while the sequencer waits for it.
	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cdone |-> state_q == ST_RUN)
		else $error("CORDIC finished outside a run");

	// Loading the merge result always presents an output transaction.
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> m_tvalid)
		else $error("merge load did not raise the output valid");

endmodule
